/* hdl/tcw_pkg.sv */
// Package with shared constants, codes and control types of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Internal widths that follow from the geometry.
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // Fixed field widths of the channels.
    localparam int KIND_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int IN_ROW_W  = 5;
    localparam int IN_COL_W  = 7;
    localparam int POS_OUT_W = 11;
    localparam int CELL_W    = 16;
    localparam int COLOR_W   = 8;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    // Attribute after reset.
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h0A;

    // Controller states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_FILL,
        ST_COPY,
        ST_FLUSH,
        ST_BLANK,
        ST_DONE
    } tcw_state_t;

    // Screen store operations.
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_PUT,
        MEM_BS,
        MEM_FILL,
        MEM_INIT,
        MEM_COPY_RD,
        MEM_CELL_RD
    } mem_op_t;

    // Cursor updates.
    typedef enum logic [2:0] {
        CUR_NONE,
        CUR_NEXT_COL,
        CUR_NEWLINE,
        CUR_BACK,
        CUR_HOME
    } cur_op_t;

    // Sweep address updates.
    typedef enum logic [1:0] {
        SCAN_HOLD,
        SCAN_ZERO,
        SCAN_BOTTOM,
        SCAN_INC
    } scan_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        mem_op_t  mem_op;
        cur_op_t  cur_op;
        scan_op_t scan_op;
        logic     cell_take;
        logic     result_load;
    } tcw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              is_newline;
        logic              is_backspace;
        logic              col_zero;
        logic              col_last;
        logic              row_last;
        logic              read_in_range;
        logic              scan_at_copy_end;
        logic              scan_at_end;
        logic              out_free;
        logic              copy_pend;
    } tcw_status_t;

endpackage

/* hdl/tcw_controller.sv */
// Controller state machine that sequences each item of the text console writer.
`timescale 1ns / 1ps

module tcw_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t   cmd,
    output logic                item_stall
);

    tcw_pkg::tcw_state_t state_reg;
    tcw_pkg::tcw_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd.capture     = 1'b0;
        cmd.mem_op      = tcw_pkg::MEM_NONE;
        cmd.cur_op      = tcw_pkg::CUR_NONE;
        cmd.scan_op     = tcw_pkg::SCAN_HOLD;
        cmd.cell_take   = 1'b0;
        cmd.result_load = 1'b0;
        item_stall      = 1'b1;

        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                // Blank the whole screen once after reset.
                cmd.mem_op  = tcw_pkg::MEM_INIT;
                cmd.scan_op = tcw_pkg::SCAN_INC;
                if (status.scan_at_end)
                begin
                    cmd.scan_op = tcw_pkg::SCAN_ZERO;
                    state_next  = tcw_pkg::ST_IDLE;
                end
            end

            tcw_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.scan_op = tcw_pkg::SCAN_ZERO;
                    state_next  = tcw_pkg::ST_EXEC;
                end
            end

            tcw_pkg::ST_EXEC:
            begin
                state_next = tcw_pkg::ST_DONE;
                case (status.kind)
                    tcw_pkg::KIND_PUT:
                    begin
                        if (status.is_newline)
                        begin
                            cmd.cur_op = tcw_pkg::CUR_NEWLINE;
                            if (status.row_last)
                            begin
                                state_next = tcw_pkg::ST_COPY;
                            end
                        end
                        else if (status.is_backspace)
                        begin
                            if (!status.col_zero)
                            begin
                                cmd.mem_op = tcw_pkg::MEM_BS;
                                cmd.cur_op = tcw_pkg::CUR_BACK;
                            end
                        end
                        else
                        begin
                            cmd.mem_op = tcw_pkg::MEM_PUT;
                            if (status.col_last)
                            begin
                                cmd.cur_op = tcw_pkg::CUR_NEWLINE;
                                if (status.row_last)
                                begin
                                    state_next = tcw_pkg::ST_COPY;
                                end
                            end
                            else
                            begin
                                cmd.cur_op = tcw_pkg::CUR_NEXT_COL;
                            end
                        end
                    end

                    tcw_pkg::KIND_READ:
                    begin
                        if (status.read_in_range)
                        begin
                            cmd.mem_op = tcw_pkg::MEM_CELL_RD;
                            state_next = tcw_pkg::ST_READ_WAIT;
                        end
                    end

                    tcw_pkg::KIND_CLEAR:
                    begin
                        state_next = tcw_pkg::ST_FILL;
                    end

                    default:
                    begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                endcase
            end

            tcw_pkg::ST_READ_WAIT:
            begin
                cmd.cell_take = 1'b1;
                state_next    = tcw_pkg::ST_DONE;
            end

            tcw_pkg::ST_FILL:
            begin
                cmd.mem_op  = tcw_pkg::MEM_FILL;
                cmd.scan_op = tcw_pkg::SCAN_INC;
                if (status.scan_at_end)
                begin
                    cmd.cur_op = tcw_pkg::CUR_HOME;
                    state_next = tcw_pkg::ST_DONE;
                end
            end

            tcw_pkg::ST_COPY:
            begin
                // Each cell moves up one row: read below, write in the following cycle.
                cmd.mem_op  = tcw_pkg::MEM_COPY_RD;
                cmd.scan_op = tcw_pkg::SCAN_INC;
                if (status.scan_at_copy_end)
                begin
                    state_next = tcw_pkg::ST_FLUSH;
                end
            end

            tcw_pkg::ST_FLUSH:
            begin
                // The last pending copy write lands in this cycle.
                cmd.scan_op = tcw_pkg::SCAN_BOTTOM;
                state_next  = tcw_pkg::ST_BLANK;
            end

            tcw_pkg::ST_BLANK:
            begin
                cmd.mem_op  = tcw_pkg::MEM_FILL;
                cmd.scan_op = tcw_pkg::SCAN_INC;
                if (status.scan_at_end)
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end

            tcw_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_INIT;
            end
        endcase
    end

endmodule

/* hdl/tcw_datapath.sv */
// Datapath of the text console writer: screen store, cursor, sweep counter and result register.
`timescale 1ns / 1ps

module tcw_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                text_color_write,
    input  logic [tcw_pkg::COLOR_W-1:0]         text_color,
    input  logic [tcw_pkg::KIND_W-1:0]          kind,
    input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
    input  logic [tcw_pkg::IN_ROW_W-1:0]        cell_row,
    input  logic [tcw_pkg::IN_COL_W-1:0]        cell_column,
    input  logic                                result_stall,
    output logic                                result_valid,
    output logic [tcw_pkg::POS_OUT_W-1:0]       cursor_position,
    output logic [tcw_pkg::IN_ROW_W-1:0]        cursor_row,
    output logic [tcw_pkg::IN_COL_W-1:0]        cursor_column,
    output logic [tcw_pkg::CELL_W-1:0]          cell_value,
    input  tcw_pkg::tcw_cmd_t                   cmd,
    output tcw_pkg::tcw_status_t                status
);

    localparam int AW = tcw_pkg::ADDR_W;

    logic [tcw_pkg::CELL_W-1:0] screen_mem [tcw_pkg::CELLS];

    logic [tcw_pkg::COLOR_W-1:0]  color_reg;
    logic [tcw_pkg::ROW_W-1:0]    row_reg;
    logic [tcw_pkg::ROW_W-1:0]    row_next;
    logic [tcw_pkg::COL_W-1:0]    col_reg;
    logic [tcw_pkg::COL_W-1:0]    col_next;
    logic [AW-1:0]                scan_reg;
    logic [AW-1:0]                scan_next;
    logic                         copy_pend_reg;
    logic [AW-1:0]                copy_addr_reg;
    logic [tcw_pkg::CELL_W-1:0]   rd_data_reg;
    logic [tcw_pkg::CELL_W-1:0]   cell_reg;
    logic [tcw_pkg::KIND_W-1:0]   item_kind_reg;
    logic [tcw_pkg::CHAR_W-1:0]   item_char_reg;
    logic [tcw_pkg::IN_ROW_W-1:0] item_row_reg;
    logic [tcw_pkg::IN_COL_W-1:0] item_col_reg;

    logic                         result_valid_reg;
    logic [tcw_pkg::POS_OUT_W-1:0] pos_out_reg;
    logic [tcw_pkg::IN_ROW_W-1:0] row_out_reg;
    logic [tcw_pkg::IN_COL_W-1:0] col_out_reg;
    logic [tcw_pkg::CELL_W-1:0]   cell_out_reg;

    logic [31:0]                  cursor_lin;
    logic [AW-1:0]                cursor_addr;
    logic [AW-1:0]                item_addr;
    logic [tcw_pkg::CELL_W-1:0]   blank_cell;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [tcw_pkg::CELL_W-1:0]   wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;

    // Linear addresses of the cursor and of the cell to read.
    assign cursor_lin  = 32'(row_reg) * tcw_pkg::COLUMNS + 32'(col_reg);
    assign cursor_addr = AW'(cursor_lin);
    assign item_addr   = AW'(32'(item_row_reg) * tcw_pkg::COLUMNS + 32'(item_col_reg));
    assign blank_cell  = {color_reg, tcw_pkg::CH_BLANK};

    // Attribute register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tcw_pkg::RESET_COLOR;
        end
        else if (text_color_write)
        begin
            color_reg <= text_color;
        end
    end

    // Captured item.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_kind_reg <= kind;
            item_char_reg <= char_code;
            item_row_reg  <= cell_row;
            item_col_reg  <= cell_column;
        end
    end

    // Cursor update.
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        case (cmd.cur_op)
            tcw_pkg::CUR_NEXT_COL:
            begin
                col_next = col_reg + 1'b1;
            end
            tcw_pkg::CUR_NEWLINE:
            begin
                col_next = '0;
                if (!status.row_last)
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            tcw_pkg::CUR_BACK:
            begin
                col_next = col_reg - 1'b1;
            end
            tcw_pkg::CUR_HOME:
            begin
                row_next = '0;
                col_next = '0;
            end
            default:
            begin
                row_next = row_reg;
                col_next = col_reg;
            end
        endcase
    end

    // Sweep address update.
    always_comb
    begin
        case (cmd.scan_op)
            tcw_pkg::SCAN_ZERO:   scan_next = '0;
            tcw_pkg::SCAN_BOTTOM: scan_next = AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
            tcw_pkg::SCAN_INC:    scan_next = scan_reg + 1'b1;
            default:              scan_next = scan_reg;
        endcase
    end

    // Cursor, sweep and copy control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            scan_reg      <= '0;
            copy_pend_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            scan_reg      <= scan_next;
            copy_pend_reg <= (cmd.mem_op == tcw_pkg::MEM_COPY_RD);
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= scan_reg;
    end

    // Write and read port selection of the screen store.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = scan_reg;
        wr_data = blank_cell;
        rd_en   = 1'b0;
        rd_addr = item_addr;
        case (cmd.mem_op)
            tcw_pkg::MEM_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = cursor_addr;
                wr_data = {color_reg, item_char_reg};
            end
            tcw_pkg::MEM_BS:
            begin
                wr_en   = 1'b1;
                wr_addr = cursor_addr - 1'b1;
            end
            tcw_pkg::MEM_FILL:
            begin
                wr_en = 1'b1;
            end
            tcw_pkg::MEM_INIT:
            begin
                wr_en   = 1'b1;
                wr_data = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_BLANK};
            end
            tcw_pkg::MEM_COPY_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = scan_reg + AW'(tcw_pkg::COLUMNS);
            end
            tcw_pkg::MEM_CELL_RD:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        // The delayed half of a copy owns the write port.
        if (copy_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rd_data_reg;
        end
    end

    // Screen store with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            screen_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

    // Cell value of the current item.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cell_reg <= '0;
        end
        else if (cmd.cell_take)
        begin
            cell_reg <= rd_data_reg;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            pos_out_reg  <= tcw_pkg::POS_OUT_W'(cursor_lin);
            row_out_reg  <= tcw_pkg::IN_ROW_W'(row_reg);
            col_out_reg  <= tcw_pkg::IN_COL_W'(col_reg);
            cell_out_reg <= cell_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign cursor_position = pos_out_reg;
    assign cursor_row      = row_out_reg;
    assign cursor_column   = col_out_reg;
    assign cell_value      = cell_out_reg;

    // Status toward the controller.
    assign status.kind             = item_kind_reg;
    assign status.is_newline       = (item_char_reg == tcw_pkg::CH_NEWLINE);
    assign status.is_backspace     = (item_char_reg == tcw_pkg::CH_BACKSPACE);
    assign status.col_zero         = (col_reg == '0);
    assign status.col_last         = (col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    assign status.row_last         = (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign status.read_in_range    = (32'(item_row_reg) < tcw_pkg::ROWS) &&
                                     (32'(item_col_reg) < tcw_pkg::COLUMNS);
    assign status.scan_at_copy_end =
        (scan_reg == AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1));
    assign status.scan_at_end      = (scan_reg == AW'(tcw_pkg::CELLS - 1));
    assign status.out_free         = !result_valid_reg || !result_stall;
    assign status.copy_pend        = copy_pend_reg;

endmodule

/* hdl/text_console_character_writer.sv */
// Top level of the text console writer: controller, datapath and checks.
//
// Usage: items arrive on item_valid/item_stall with kind, char_code, cell_row and
// cell_column. A transfer happens at a rising edge with valid high and stall low.
// Every item gives exactly one result on result_valid/result_stall carrying the
// cursor after the item and, for a read, the addressed cell (otherwise zero).
// text_color_write with text_color sets the attribute of new characters and blanks.
// A put, newline or backspace passes through the execute and done states before its
// result is registered; a read adds a wait state for the store's registered read data.
// A clear sweeps the 2000-cell store one cell per cycle; a newline or wrap past the
// bottom row scrolls, which moves 1920 cells through the single read and write port
// and blanks 80 more. One item is in work at a time; the next transfer can be taken
// in the cycle after the result is loaded into the output register, so a stalled
// result does not block the next item's transfer.
// After reset a clearing pass writes a blank to every cell, during which item_stall
// stays high; attribute writes are taken throughout.
// While the receiver stalls, the result register holds its contents.
`timescale 1ns / 1ps

module text_console_character_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          text_color_write,
    input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [tcw_pkg::KIND_W-1:0]    kind,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::IN_ROW_W-1:0]  cell_row,
    input  logic [tcw_pkg::IN_COL_W-1:0]  cell_column,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [tcw_pkg::POS_OUT_W-1:0] cursor_position,
    output logic [tcw_pkg::IN_ROW_W-1:0]  cursor_row,
    output logic [tcw_pkg::IN_COL_W-1:0]  cursor_column,
    output logic [tcw_pkg::CELL_W-1:0]    cell_value
);

    tcw_pkg::tcw_cmd_t    cmd;
    tcw_pkg::tcw_status_t status;

    // Sequencing.
    tcw_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .status     (status),
        .cmd        (cmd),
        .item_stall (item_stall)
    );

    // Storage and arithmetic.
    tcw_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .text_color_write (text_color_write),
        .text_color       (text_color),
        .kind             (kind),
        .char_code        (char_code),
        .cell_row         (cell_row),
        .cell_column      (cell_column),
        .result_stall     (result_stall),
        .result_valid     (result_valid),
        .cursor_position  (cursor_position),
        .cursor_row       (cursor_row),
        .cursor_column    (cursor_column),
        .cell_value       (cell_value),
        .cmd              (cmd),
        .status           (status)
    );

    // A result is loaded only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> status.out_free)
        else $error("result loaded over an untaken result");

    // An accepted item is followed by a stall while it is in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second item accepted while one is in work");

    // The delayed copy write never shares the port with another store write.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.copy_pend |-> (cmd.mem_op == tcw_pkg::MEM_NONE ||
                              cmd.mem_op == tcw_pkg::MEM_COPY_RD))
        else $error("store write collides with pending copy");

    // A reported cursor stays on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(cursor_column) < tcw_pkg::COLUMNS &&
                          32'(cursor_row) < tcw_pkg::ROWS))
        else $error("cursor reported off screen");

endmodule
